### rtl/adcfp_pkg.sv
`timescale 1ns / 1ps

package adcfp_pkg;

	// Character codes of the serial protocol
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_SEP     = 8'd97;   // 'a' closes a field
	localparam logic [7:0] CH_DISCARD = 8'd98;   // 'b' drops pending fields
	localparam logic [7:0] CH_END     = 8'd101;  // 'e' ends the frame

	// Pending slots: identifier, length, then eight data bytes
	localparam int unsigned NUM_SLOTS  = 10;
	localparam int unsigned SLOT_W     = 11;
	localparam int unsigned IDX_W      = $clog2(NUM_SLOTS + 1);
	localparam int unsigned SLOT_SEL_W = $clog2(NUM_SLOTS);
	localparam int unsigned NUM_DATA   = 8;

	localparam logic [IDX_W-1:0] IDX_SAT     = IDX_W'(NUM_SLOTS);
	localparam logic [3:0]       DEFAULT_LEN = 4'd8;

	typedef logic [7:0]        data_byte_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef data_byte_t        data_arr_t [NUM_DATA];

	// Data bytes of the kept frame after reset
	localparam data_arr_t HELD_DATA_INIT = '{
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd6, 8'd7
	};

endpackage

### rtl/ascii_decimal_to_can_frame_parser.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------------
// input    in_valid / in_ready  rx_byte[7:0]
// output   out_valid/out_ready  frame_id[10:0], frame_len[3:0], byte0..byte7
//
// One character per cycle; every character is handled in the cycle it is
// accepted, and an 'e' loads the frame into the output register.
// A waiting frame only holds back a further 'e': all other characters are
// still taken, since they touch parser state and not the output register.
// Asynchronous active-low reset clears the parser and sets the kept frame to
// defaults; pending slot contents are not reset, only their written mask.
module ascii_decimal_to_can_frame_parser
	import adcfp_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] frame_id,
	output logic [3:0]  frame_len,
	output logic [7:0]  byte0,
	output logic [7:0]  byte1,
	output logic [7:0]  byte2,
	output logic [7:0]  byte3,
	output logic [7:0]  byte4,
	output logic [7:0]  byte5,
	output logic [7:0]  byte6,
	output logic [7:0]  byte7
);

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	// Parser state
	logic [31:0]           acc_q;
	logic [CNT_W-1:0]      digit_cnt_q;
	logic [IDX_W-1:0]      field_idx_q;
	logic [NUM_SLOTS-1:0]  pend_mask_q;
	slot_t                 pend_q [NUM_SLOTS];
	logic [10:0]           held_id_q;
	logic [3:0]            held_len_q;
	data_arr_t             held_data_q;

	// Output register
	logic                  out_valid_q;
	logic [10:0]           out_id_q;
	logic [3:0]            out_len_q;
	data_arr_t             out_data_q;

	logic                  in_txn;
	logic                  is_digit, is_sep, is_end, is_discard;
	logic [31:0]           acc_next;
	logic [10:0]           merge_id;
	logic [3:0]            merge_len;
	data_arr_t             merge_data;

	// Character decode
	assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_sep     = (rx_byte == CH_SEP);
	assign is_end     = (rx_byte == CH_END);
	assign is_discard = (rx_byte == CH_DISCARD);

	// Only a frame end needs room in the output register
	assign in_ready = !out_valid_q || out_ready || !is_end;
	assign in_txn   = in_valid && in_ready;

	// acc * 10 + digit, wrapping at 32 bits
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, rx_byte[3:0] - CH_ZERO[3:0]};

	// Merge written pending slots over the kept frame
	always_comb begin
		merge_id  = pend_mask_q[0] ? pend_q[0] : held_id_q;
		merge_len = pend_mask_q[1] ? pend_q[1][3:0] : held_len_q;
		for (int k = 0; k < NUM_DATA; k++) begin
			merge_data[k] = pend_mask_q[k+2] ? pend_q[k+2][7:0] : held_data_q[k];
		end
	end

	// Control state and kept frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			digit_cnt_q <= '0;
			field_idx_q <= '0;
			pend_mask_q <= '0;
			held_id_q   <= '0;
			held_len_q  <= DEFAULT_LEN;
			held_data_q <= HELD_DATA_INIT;
			out_valid_q <= 1'b0;
		end else begin
			// a new frame takes the output register, otherwise it drains
			if (in_txn && is_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_txn) begin
				priority if (is_digit) begin
					if (digit_cnt_q < CNT_MAX) begin
						acc_q       <= acc_next;
						digit_cnt_q <= digit_cnt_q + 1'b1;
					end
				end else if (is_sep) begin
					if (field_idx_q < IDX_SAT) begin
						pend_mask_q[field_idx_q[SLOT_SEL_W-1:0]] <= 1'b1;
						field_idx_q <= field_idx_q + 1'b1;
					end
					acc_q       <= '0;
					digit_cnt_q <= '0;
				end else if (is_discard) begin
					pend_mask_q <= '0;
					field_idx_q <= '0;
				end else if (is_end) begin
					held_id_q   <= merge_id;
					held_data_q <= merge_data;
					held_len_q  <= DEFAULT_LEN;
					field_idx_q <= '0;
					pend_mask_q <= '0;
				end else begin
					// other characters are ignored
				end
			end
		end
	end

	// Pending slot contents, validated by pend_mask_q
	always_ff @(posedge clk) begin
		if (in_txn && is_sep && (field_idx_q < IDX_SAT)) begin
			pend_q[field_idx_q[SLOT_SEL_W-1:0]] <= acc_q[SLOT_W-1:0];
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (in_txn && is_end) begin
			out_id_q   <= merge_id;
			out_len_q  <= merge_len;
			out_data_q <= merge_data;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_id  = out_id_q;
	assign frame_len = out_len_q;
	assign byte0     = out_data_q[0];
	assign byte1     = out_data_q[1];
	assign byte2     = out_data_q[2];
	assign byte3     = out_data_q[3];
	assign byte4     = out_data_q[4];
	assign byte5     = out_data_q[5];
	assign byte6     = out_data_q[6];
	assign byte7     = out_data_q[7];

endmodule
